>>> rtl/farbfeld_glyph_image_parser_top_defines.svh
// Assertion macros for the farbfeld glyph image parser checker.
// No dependencies; included by the checker file.
`ifndef FARBFELD_GLYPH_IMAGE_PARSER_TOP_DEFINES_SVH
`define FARBFELD_GLYPH_IMAGE_PARSER_TOP_DEFINES_SVH

// Property checked only outside reset.
`define FGIP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("fgip assertion failed");

// Property checked on every edge, reset included.
`define FGIP_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("fgip assertion failed");

`endif

>>> rtl/fgip_pkg.sv
// Shared types and constants for the farbfeld glyph image parser.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fgip_pkg;

   localparam logic [1:0] KIND_DIMS      = 2'd0;
   localparam logic [1:0] KIND_PIXEL     = 2'd1;
   localparam logic [1:0] KIND_BAD_MAGIC = 2'd2;

   localparam logic [1:0] PHASE_MAGIC  = 2'd0;
   localparam logic [1:0] PHASE_DIMS   = 2'd1;
   localparam logic [1:0] PHASE_PIXELS = 2'd2;
   localparam logic [1:0] PHASE_HALTED = 2'd3;

   localparam logic [2:0] LAST_BYTE_POS = 3'd7;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] dim_width;
      logic [31:0] dim_height;
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic [7:0]  glyph_first;
      logic [7:0]  glyph_second;
      logic        last_pixel;
   } result_type;

   // "farbfeld"
   function automatic logic [7:0] magic_byte(input logic [2:0] pos);
      logic [7:0] value;
      case (pos)
         3'd0: value = 8'h66;
         3'd1: value = 8'h61;
         3'd2: value = 8'h72;
         3'd3: value = 8'h62;
         3'd4: value = 8'h66;
         3'd5: value = 8'h65;
         3'd6: value = 8'h6C;
         3'd7: value = 8'h64;
         default: value = 8'h00;
      endcase
      return value;
   endfunction

endpackage

`default_nettype wire

>>> rtl/fgip_core.sv
// Byte parser: header check, dimension capture, pixel record decode.
// Depends on fgip_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fgip_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               take,
   input  wire logic [7:0]         byte_value,
   output logic                    res_valid,
   output fgip_pkg::result_type    res
);

   logic [1:0]  phase_ff,    phase_in;
   logic [2:0]  pos_ff,      pos_in;
   logic [31:0] width_ff,    width_in;
   logic [31:0] height_ff,   height_in;
   logic [31:0] column_ff,   column_in;
   logic [31:0] row_ff,      row_in;
   logic [55:0] record_ff,   record_in;
   logic        mismatch_ff, mismatch_in;

   logic        eighth;
   logic        mism;
   logic [31:0] height_new;
   logic        col_end;
   logic        row_end;

   assign eighth     = (pos_ff == fgip_pkg::LAST_BYTE_POS);
   assign mism       = mismatch_ff | (byte_value != fgip_pkg::magic_byte(pos_ff));
   assign height_new = {height_ff[23:0], byte_value};
   assign col_end    = (column_ff == width_ff - 32'd1);
   assign row_end    = (row_ff == height_ff - 32'd1);

   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      column_in   = column_ff;
      row_in      = row_ff;
      record_in   = record_ff;
      mismatch_in = mismatch_ff;
      res_valid   = 1'b0;
      res         = '0;
      if (take) begin
         case (phase_ff)
            fgip_pkg::PHASE_MAGIC: begin
               pos_in      = pos_ff + 3'd1;
               mismatch_in = mism;
               if (eighth) begin
                  if (mism) begin
                     phase_in  = fgip_pkg::PHASE_HALTED;
                     res_valid = 1'b1;
                     res.kind  = fgip_pkg::KIND_BAD_MAGIC;
                  end else begin
                     phase_in = fgip_pkg::PHASE_DIMS;
                  end
               end
            end
            fgip_pkg::PHASE_DIMS: begin
               pos_in = pos_ff + 3'd1;
               if (!pos_ff[2]) begin
                  width_in = {width_ff[23:0], byte_value};
               end else begin
                  height_in = height_new;
               end
               if (eighth) begin
                  res_valid      = 1'b1;
                  res.kind       = fgip_pkg::KIND_DIMS;
                  res.dim_width  = width_ff;
                  res.dim_height = height_new;
                  column_in      = '0;
                  row_in         = '0;
                  record_in      = '0;
                  if (width_ff == 32'd0 || height_new == 32'd0) begin
                     res.last_pixel = 1'b1;
                     phase_in       = fgip_pkg::PHASE_MAGIC;
                     mismatch_in    = 1'b0;
                  end else begin
                     phase_in = fgip_pkg::PHASE_PIXELS;
                  end
               end
            end
            fgip_pkg::PHASE_PIXELS: begin
               pos_in = pos_ff + 3'd1;
               if (!eighth) begin
                  record_in = {record_ff[47:0], byte_value};
               end else begin
                  record_in        = '0;
                  res_valid        = 1'b1;
                  res.kind         = fgip_pkg::KIND_PIXEL;
                  res.red          = record_ff[55:40];
                  res.green        = record_ff[39:24];
                  res.blue         = record_ff[23:8];
                  res.glyph_first  = record_ff[7:0];
                  res.glyph_second = byte_value;
                  res.last_pixel   = col_end & row_end;
                  if (col_end && row_end) begin
                     phase_in    = fgip_pkg::PHASE_MAGIC;
                     mismatch_in = 1'b0;
                     column_in   = '0;
                     row_in      = '0;
                  end else if (col_end) begin
                     column_in = '0;
                     row_in    = row_ff + 32'd1;
                  end else begin
                     column_in = column_ff + 32'd1;
                  end
               end
            end
            default: begin
               // halted after a bad header: bytes are dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= fgip_pkg::PHASE_MAGIC;
         pos_ff      <= '0;
         width_ff    <= '0;
         height_ff   <= '0;
         column_ff   <= '0;
         row_ff      <= '0;
         record_ff   <= '0;
         mismatch_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         column_ff   <= column_in;
         row_ff      <= row_in;
         record_ff   <= record_in;
         mismatch_ff <= mismatch_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/fgip_outbuf.sv
// Result register with a one-entry skid stage.
// Depends on fgip_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fgip_outbuf (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire fgip_pkg::result_type  in_result,
   output logic                       full,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output fgip_pkg::result_type       out_result
);

   logic                 out_valid_ff, out_valid_in;
   fgip_pkg::result_type out_data_ff,  out_data_in;
   logic                 skid_valid_ff, skid_valid_in;
   fgip_pkg::result_type skid_data_ff,  skid_data_in;
   logic                 out_take;

   assign out_take = out_valid_ff & ~rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // input side is stalled while the skid entry is held
         if (out_take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!out_valid_ff || out_take) begin
            out_valid_in = 1'b1;
            out_data_in  = in_result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = in_result;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full       = skid_valid_ff;
   assign rsp_valid  = out_valid_ff;
   assign out_result = out_data_ff;

endmodule

`default_nettype wire

>>> rtl/farbfeld_glyph_image_parser_top.sv
// Farbfeld-style image stream parser with two glyph bytes per pixel.
// Input: one file byte per transaction on req_ (valid/stall).
// Output: at most one transaction per byte on rsp_ (valid/stall):
//   kind dims  - width and height after the 16 header bytes; last_pixel is
//                set when either is zero and the next byte opens a new header.
//   kind pixel - one per 8-byte record, last_pixel on the final one.
//   kind bad   - after the eighth magic byte if the magic was wrong; every
//                later byte is accepted and dropped until reset.
// Fields not belonging to a kind read as zero.
// Throughput: one byte per cycle while req_stall is low. A completed result is
// registered in the result register, or in the skid entry while that is held.
// A result register plus one skid entry sit on the output; req_stall rises
// only while the skid entry is occupied, i.e. after the receiver has held
// rsp_stall with a result waiting and another result arrived.
// Reset (synchronous) returns the parser to expecting the magic word and
// drops any pending results.
// Depends on fgip_pkg, fgip_core, fgip_outbuf.
`timescale 1ns / 1ps
`default_nettype none

module farbfeld_glyph_image_parser_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_byte_value,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_kind,
   output logic [31:0]      rsp_dim_width,
   output logic [31:0]      rsp_dim_height,
   output logic [15:0]      rsp_red,
   output logic [15:0]      rsp_green,
   output logic [15:0]      rsp_blue,
   output logic [7:0]       rsp_glyph_first,
   output logic [7:0]       rsp_glyph_second,
   output logic             rsp_last_pixel
);

   logic                 take;
   logic                 res_valid;
   fgip_pkg::result_type res;
   fgip_pkg::result_type out_result;
   logic                 buf_full;

   assign req_stall = buf_full;
   assign take      = req_valid & ~buf_full;

   fgip_core u_core (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .byte_value (req_byte_value),
      .res_valid  (res_valid),
      .res        (res)
   );

   fgip_outbuf u_outbuf (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (res_valid),
      .in_result  (res),
      .full       (buf_full),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .out_result (out_result)
   );

   assign rsp_kind         = out_result.kind;
   assign rsp_dim_width    = out_result.dim_width;
   assign rsp_dim_height   = out_result.dim_height;
   assign rsp_red          = out_result.red;
   assign rsp_green        = out_result.green;
   assign rsp_blue         = out_result.blue;
   assign rsp_glyph_first  = out_result.glyph_first;
   assign rsp_glyph_second = out_result.glyph_second;
   assign rsp_last_pixel   = out_result.last_pixel;

endmodule

`default_nettype wire

>>> rtl/fgip_checker.sv
// Port-level checks for the farbfeld glyph image parser, bound to the top.
// Depends on fgip_pkg and farbfeld_glyph_image_parser_top_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "farbfeld_glyph_image_parser_top_defines.svh"

module fgip_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [1:0]  rsp_kind,
   input  wire logic [31:0] rsp_dim_width,
   input  wire logic [31:0] rsp_dim_height,
   input  wire logic [15:0] rsp_red,
   input  wire logic        rsp_last_pixel
);

   // results are dropped by reset
   `FGIP_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_valid)

   // a stalled transaction is held
   `FGIP_ASSERT(a_rsp_held, clock, reset, rsp_valid && rsp_stall |=> rsp_valid)

   // bad magic never ends an image
   `FGIP_ASSERT(a_bad_not_last, clock, reset,
      rsp_valid && rsp_kind == fgip_pkg::KIND_BAD_MAGIC |-> !rsp_last_pixel)

   // dims and bad-magic transactions carry no red; bad magic carries no dimensions
   `FGIP_ASSERT(a_field_exclusive, clock, reset,
      rsp_valid |-> (rsp_kind == fgip_pkg::KIND_PIXEL) ||
         (rsp_red == 16'd0 && (rsp_kind == fgip_pkg::KIND_DIMS ||
          (rsp_dim_width == 32'd0 && rsp_dim_height == 32'd0))))

endmodule

bind farbfeld_glyph_image_parser_top fgip_checker u_fgip_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_kind       (rsp_kind),
   .rsp_dim_width  (rsp_dim_width),
   .rsp_dim_height (rsp_dim_height),
   .rsp_red        (rsp_red),
   .rsp_last_pixel (rsp_last_pixel)
);

`default_nettype wire
